@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL of the affine patch warp block; used by apwb_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define APWB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apwb assertion failed");

// Next-cycle implication, disabled while reset is high.
`define APWB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apwb assertion failed");

`endif

@@ rtl/core/apwb_pkg.sv @@
// Shared types, widths and codes of the affine patch warp block.
package apwb_pkg;

  localparam int MAX_COLS_DEF   = 128;
  localparam int MAX_ROWS_DEF   = 128;
  localparam int MAX_HALF_DEF   = 4;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PATCH = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_WARP  = 1'b1;

  localparam int CENTRE_W = 20;
  localparam int MAT_W    = 16;
  localparam int PROD_W   = 32;   // a*a product
  localparam int DET_W    = 33;
  localparam int DEN_W    = 32;   // |det|
  localparam int DX_W     = 12;   // scaled patch offset
  localparam int MPROD_W  = 28;   // a*dx product
  localparam int NUM_W    = 29;
  localparam int MAG_W    = 26;   // |numerator|
  localparam int FRAC_SH  = 20;
  localparam int DVD_W    = MAG_W + FRAC_SH;
  localparam int PX_W     = 48;
  localparam int WGT_W    = 17;
  localparam int ACC_W    = 24;

  typedef struct packed {
    logic                     command;
    logic [6:0]               pix_x;
    logic [6:0]               pix_y;
    logic [7:0]               pix_value;
    logic signed [MAT_W-1:0]  mat_a00;
    logic signed [MAT_W-1:0]  mat_a01;
    logic signed [MAT_W-1:0]  mat_a10;
    logic signed [MAT_W-1:0]  mat_a11;
    logic [CENTRE_W-1:0]      ref_x;
    logic [CENTRE_W-1:0]      ref_y;
    logic [2:0]               level_ref;
    logic [2:0]               level_cur;
  } in_t;

  typedef struct packed {
    logic [7:0] patch_value;
    logic [5:0] patch_index;
    logic       last;
    logic       status;
  } out_t;

  typedef struct packed {
    logic                     command;
    logic                     wr_ok;
    logic [6:0]               pix_x;
    logic [6:0]               pix_y;
    logic [7:0]               pix_value;
    logic signed [MAT_W-1:0]  a00;
    logic signed [MAT_W-1:0]  a01;
    logic signed [MAT_W-1:0]  a10;
    logic signed [MAT_W-1:0]  a11;
    logic [CENTRE_W-1:0]      cx;
    logic [CENTRE_W-1:0]      cy;
    logic [2:0]               level_cur;
  } qitem_t;

  typedef struct packed {
    logic [7:0] cols;
    logic [7:0] rows;
    logic [2:0] half;
  } geom_t;

endpackage

@@ rtl/core/apwb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module apwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/apwb_front.sv @@
// Front stage: accepts transactions, decodes them and prepares queue entries.
module apwb_front #(
  parameter int MAX_COLS = apwb_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = apwb_pkg::MAX_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  apwb_pkg::in_t    in_data,
  output logic             q_valid,
  input  logic             q_ready,
  output apwb_pkg::qitem_t q_item
);

  logic             fr_valid;
  apwb_pkg::qitem_t fr_item;
  apwb_pkg::qitem_t dec;

  // The centre is floored to the reference pyramid level here.
  always_comb begin
    dec.command   = in_data.command;
    dec.wr_ok     = (int'(in_data.pix_x) < MAX_COLS) && (int'(in_data.pix_y) < MAX_ROWS);
    dec.pix_x     = in_data.pix_x;
    dec.pix_y     = in_data.pix_y;
    dec.pix_value = in_data.pix_value;
    dec.a00       = in_data.mat_a00;
    dec.a01       = in_data.mat_a01;
    dec.a10       = in_data.mat_a10;
    dec.a11       = in_data.mat_a11;
    dec.cx        = in_data.ref_x >> in_data.level_ref;
    dec.cy        = in_data.ref_y >> in_data.level_ref;
    dec.level_cur = in_data.level_cur;
  end

  assign in_ready = !fr_valid || q_ready;
  assign q_valid  = fr_valid;
  assign q_item   = fr_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_ready) begin
      fr_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      fr_item <= dec;
    end
  end

endmodule

@@ rtl/core/apwb_fifo.sv @@
// Short register queue between the front and the back.
module apwb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = apwb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/apwb_back.sv @@
// Back engine: pixel writes, matrix inversion, per-point division and bilinear sampling.
`include "assert_macros.svh"

module apwb_back #(
  parameter int MAX_COLS = apwb_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = apwb_pkg::MAX_ROWS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  apwb_pkg::geom_t                          geom,
  input  logic                                     q_valid,
  input  apwb_pkg::qitem_t                         q_item,
  output logic                                     q_pop,
  output logic                                     ram_we,
  output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]     ram_waddr,
  output logic [7:0]                               ram_wdata,
  output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]     ram_raddr,
  input  logic [7:0]                               ram_rdata,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output apwb_pkg::out_t                           out_data
);

  localparam int ADDR_W = $clog2(MAX_COLS * MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int PX_W   = apwb_pkg::PX_W;
  localparam int DEN_W  = apwb_pkg::DEN_W;
  localparam int DVD_W  = apwb_pkg::DVD_W;
  localparam int CNT_W  = $clog2(DVD_W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DET1, S_DET2, S_DETCHK, S_MUL, S_SUB, S_DIV, S_POS, S_CHK, S_RD, S_SEND
  } state_t;

  state_t                              state;
  apwb_pkg::qitem_t                    cur;
  logic signed [apwb_pkg::PROD_W-1:0]  p0, p1;
  logic signed [apwb_pkg::DET_W-1:0]   det;
  logic [DEN_W-1:0]                    ud;
  logic                                det_neg;
  logic                                sing;
  logic [2:0]                          pxi, pyi;
  logic signed [apwb_pkg::MPROD_W-1:0] m0, m1, m2, m3;
  logic [DVD_W-1:0]                    dvd_x, dvd_y;
  logic [DEN_W-1:0]                    rem_x, rem_y;
  logic                                sgn_x, sgn_y;
  logic [CNT_W-1:0]                    cnt;
  logic signed [PX_W-1:0]              px, py;
  logic [apwb_pkg::WGT_W-1:0]          w [4];
  logic [ADDR_W-1:0]                   base;
  logic [2:0]                          k;
  logic [apwb_pkg::ACC_W-1:0]          acc;

  // Combinational helpers.
  logic [3:0]                          side;
  logic signed [3:0]                   off_x, off_y;
  logic signed [apwb_pkg::DX_W-1:0]    dx, dy;
  logic signed [apwb_pkg::NUM_W-1:0]   nx, ny, nx_mag, ny_mag;
  logic [DEN_W:0]                      rsh_x, rsh_y, rnx_x, rnx_y;
  logic                                ge_x, ge_y;
  logic [PX_W-1:0]                     qx, qy, adj_x, adj_y;
  logic signed [PX_W-1:0]              sx, sy, lim_x, lim_y;
  logic                                outside;
  logic [8:0]                          wx0, wx1, wy0, wy1;
  logic [17:0]                         w00, w01, w10, w11;
  logic [1:0]                          wsel;
  logic [24:0]                         prod;
  logic [5:0]                          idx;
  logic                                at_last;
  logic                                out_free;

  assign side  = {geom.half, 1'b0};
  assign off_x = $signed({1'b0, pxi}) - $signed({1'b0, geom.half});
  assign off_y = $signed({1'b0, pyi}) - $signed({1'b0, geom.half});
  assign dx    = apwb_pkg::DX_W'(off_x) <<< cur.level_cur;
  assign dy    = apwb_pkg::DX_W'(off_y) <<< cur.level_cur;

  assign nx     = apwb_pkg::NUM_W'(m0) - apwb_pkg::NUM_W'(m1);
  assign ny     = apwb_pkg::NUM_W'(m2) - apwb_pkg::NUM_W'(m3);
  assign nx_mag = nx[apwb_pkg::NUM_W-1] ? -nx : nx;
  assign ny_mag = ny[apwb_pkg::NUM_W-1] ? -ny : ny;

  // One restoring division step per cycle for each coordinate.
  assign rsh_x = {rem_x, dvd_x[DVD_W-1]};
  assign rsh_y = {rem_y, dvd_y[DVD_W-1]};
  assign ge_x  = rsh_x >= {1'b0, ud};
  assign ge_y  = rsh_y >= {1'b0, ud};
  assign rnx_x = ge_x ? rsh_x - {1'b0, ud} : rsh_x;
  assign rnx_y = ge_y ? rsh_y - {1'b0, ud} : rsh_y;

  // Floor correction of the magnitude quotient.
  assign qx    = {{(PX_W-DVD_W){1'b0}}, dvd_x};
  assign qy    = {{(PX_W-DVD_W){1'b0}}, dvd_y};
  assign adj_x = qx + PX_W'(rem_x != '0);
  assign adj_y = qy + PX_W'(rem_y != '0);
  assign sx    = sgn_x ? -$signed(adj_x) : $signed(qx);
  assign sy    = sgn_y ? -$signed(adj_y) : $signed(qy);

  assign lim_x = ($signed({{(PX_W-8){1'b0}}, geom.cols}) - PX_W'(1)) <<< 8;
  assign lim_y = ($signed({{(PX_W-8){1'b0}}, geom.rows}) - PX_W'(1)) <<< 8;
  assign outside = px[PX_W-1] || py[PX_W-1] || (px >= lim_x) || (py >= lim_y);

  assign wx1 = {1'b0, px[7:0]};
  assign wy1 = {1'b0, py[7:0]};
  assign wx0 = 9'd256 - wx1;
  assign wy0 = 9'd256 - wy1;
  assign w00 = wx0 * wy0;
  assign w01 = wx0 * wy1;
  assign w10 = wx1 * wy0;
  assign w11 = wx1 * wy1;

  assign wsel = 2'(k - 3'd1);
  assign prod = {17'd0, ram_rdata} * {8'd0, w[wsel]};

  assign idx     = 6'(int'(pyi) * int'(side) + int'(pxi));
  assign at_last = (4'(pxi) == side - 4'd1) && (4'(pyi) == side - 4'd1);
  assign out_free = !out_valid || out_ready;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign ram_we    = q_pop && (q_item.command == apwb_pkg::CMD_WRITE) && q_item.wr_ok;
  assign ram_waddr = ADDR_W'(int'(q_item.pix_y) * MAX_COLS + int'(q_item.pix_x));
  assign ram_wdata = q_item.pix_value;

  always_comb begin
    case (k)
      3'd0:    ram_raddr = base;
      3'd1:    ram_raddr = ADDR_W'(int'(base) + MAX_COLS);
      3'd2:    ram_raddr = ADDR_W'(int'(base) + 1);
      3'd3:    ram_raddr = ADDR_W'(int'(base) + MAX_COLS + 1);
      default: ram_raddr = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid && q_item.command == apwb_pkg::CMD_WARP) begin
            cur   <= q_item;
            state <= S_DET1;
          end
        end
        S_DET1: begin
          p0    <= apwb_pkg::PROD_W'(cur.a00) * apwb_pkg::PROD_W'(cur.a11);
          p1    <= apwb_pkg::PROD_W'(cur.a01) * apwb_pkg::PROD_W'(cur.a10);
          state <= S_DET2;
        end
        S_DET2: begin
          det   <= apwb_pkg::DET_W'(p0) - apwb_pkg::DET_W'(p1);
          state <= S_DETCHK;
        end
        S_DETCHK: begin
          det_neg <= det[apwb_pkg::DET_W-1];
          ud      <= det[apwb_pkg::DET_W-1] ? DEN_W'(-det) : DEN_W'(det);
          pxi     <= '0;
          pyi     <= '0;
          acc     <= '0;
          sing    <= (det == '0);
          state   <= (det == '0) ? S_SEND : S_MUL;
        end
        S_MUL: begin
          m0    <= apwb_pkg::MPROD_W'(cur.a11) * apwb_pkg::MPROD_W'(dx);
          m1    <= apwb_pkg::MPROD_W'(cur.a01) * apwb_pkg::MPROD_W'(dy);
          m2    <= apwb_pkg::MPROD_W'(cur.a00) * apwb_pkg::MPROD_W'(dy);
          m3    <= apwb_pkg::MPROD_W'(cur.a10) * apwb_pkg::MPROD_W'(dx);
          state <= S_SUB;
        end
        S_SUB: begin
          dvd_x <= {nx_mag[apwb_pkg::MAG_W-1:0], {apwb_pkg::FRAC_SH{1'b0}}};
          dvd_y <= {ny_mag[apwb_pkg::MAG_W-1:0], {apwb_pkg::FRAC_SH{1'b0}}};
          sgn_x <= nx[apwb_pkg::NUM_W-1] ^ det_neg;
          sgn_y <= ny[apwb_pkg::NUM_W-1] ^ det_neg;
          rem_x <= '0;
          rem_y <= '0;
          cnt   <= CNT_W'(DVD_W);
          state <= S_DIV;
        end
        S_DIV: begin
          rem_x <= rnx_x[DEN_W-1:0];
          rem_y <= rnx_y[DEN_W-1:0];
          dvd_x <= {dvd_x[DVD_W-2:0], ge_x};
          dvd_y <= {dvd_y[DVD_W-2:0], ge_y};
          cnt   <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= S_POS;
          end
        end
        S_POS: begin
          px    <= sx + $signed({{(PX_W-apwb_pkg::CENTRE_W){1'b0}}, cur.cx});
          py    <= sy + $signed({{(PX_W-apwb_pkg::CENTRE_W){1'b0}}, cur.cy});
          state <= S_CHK;
        end
        S_CHK: begin
          acc   <= '0;
          w[0]  <= w00[apwb_pkg::WGT_W-1:0];
          w[1]  <= w01[apwb_pkg::WGT_W-1:0];
          w[2]  <= w10[apwb_pkg::WGT_W-1:0];
          w[3]  <= w11[apwb_pkg::WGT_W-1:0];
          base  <= ADDR_W'(int'(py[8 +: ROW_W]) * MAX_COLS + int'(px[8 +: COL_W]));
          k     <= '0;
          state <= outside ? S_SEND : S_RD;
        end
        S_RD: begin
          k <= k + 3'd1;
          if (k != 3'd0) begin
            acc <= acc + prod[apwb_pkg::ACC_W-1:0];
          end
          if (k == 3'd4) begin
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.patch_value <= acc[apwb_pkg::ACC_W-1 -: 8];
            out_data.patch_index <= sing ? 6'd0 : idx;
            out_data.last        <= sing || at_last;
            out_data.status      <= sing;
            if (sing || at_last) begin
              state <= S_IDLE;
            end else begin
              if (4'(pxi) == side - 4'd1) begin
                pxi <= '0;
                pyi <= pyi + 3'd1;
              end else begin
                pxi <= pxi + 3'd1;
              end
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `APWB_ASSERT_IMPL(a_rd_inside, state == S_RD, !px[PX_W-1] && !py[PX_W-1])
  `APWB_ASSERT_IMPL(a_sing_det, state == S_SEND && sing, det == '0)
  `APWB_ASSERT_IMPL(a_cnt_range, state == S_MUL, (4'(pxi) < side) && (4'(pyi) < side))

endmodule

@@ rtl/core/affine_patch_warp_bilinear.sv @@
// Top level of the affine patch warp block with bilinear sampling.
//
// Input channel (in_valid/in_ready/in_data) carries one transaction per item.
// A pixel write (command 0) stores one 8-bit pixel of the reference image, if
// it lies inside MAX_COLS x MAX_ROWS, and yields no result; writes retire at
// one per cycle while the engine is idle. A warp (command 1) yields one result
// transaction per patch pixel in raster order, (2*half_patch)^2 of them, with
// last set on the final one; a singular matrix yields a single result with
// status 1. A warp first computes the determinant; each patch pixel then
// runs two 46-step bit-serial dividers side by side, then four reads of the
// single-read image RAM, skipped when the point falls outside the image.
// A front register and a two-entry queue decouple input from the engine, and
// an output register decouples the engine from the receiver: when the
// receiver stalls, the engine holds its next result and the queue keeps
// accepting until full. Reset (rst, synchronous) empties the queue, idles the
// engine and sets image_cols/image_rows to 128 and half_patch to 4. The image
// RAM is not cleared; reading a pixel never written returns undefined data.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect the next cycle.
module affine_patch_warp_bilinear #(
  parameter int MAX_COLS       = apwb_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS       = apwb_pkg::MAX_ROWS_DEF,
  parameter int MAX_HALF_PATCH = apwb_pkg::MAX_HALF_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  apwb_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output apwb_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [apwb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apwb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_COLS * MAX_ROWS);
  localparam int QW     = $bits(apwb_pkg::qitem_t);

  logic [7:0]       image_cols;
  logic [7:0]       image_rows;
  logic [2:0]       half_patch;
  apwb_pkg::geom_t  geom;

  logic             fq_valid, fq_ready;
  apwb_pkg::qitem_t fq_item;
  logic             bq_valid, bq_pop;
  logic [QW-1:0]    bq_bits;
  apwb_pkg::qitem_t bq_item;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= 8'd128;
      image_rows <= 8'd128;
      half_patch <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        apwb_pkg::CFG_IMAGE_COLS: image_cols <= cfg_data;
        apwb_pkg::CFG_IMAGE_ROWS: image_rows <= cfg_data;
        apwb_pkg::CFG_HALF_PATCH: half_patch <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Sizes saturate to the stored window; the half side to 1..MAX_HALF_PATCH.
  always_comb begin
    geom.cols = (int'(image_cols) > MAX_COLS) ? 8'(MAX_COLS) : image_cols;
    geom.rows = (int'(image_rows) > MAX_ROWS) ? 8'(MAX_ROWS) : image_rows;
    if (half_patch == 3'd0) begin
      geom.half = 3'd1;
    end else if (int'(half_patch) > MAX_HALF_PATCH) begin
      geom.half = 3'(MAX_HALF_PATCH);
    end else begin
      geom.half = half_patch;
    end
  end

  apwb_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  apwb_fifo #(
    .WIDTH(QW),
    .DEPTH(apwb_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_item),
    .pop_valid  (bq_valid),
    .pop        (bq_pop),
    .pop_data   (bq_bits)
  );

  assign bq_item = apwb_pkg::qitem_t'(bq_bits);

  apwb_ram #(
    .WIDTH(8),
    .DEPTH(MAX_COLS * MAX_ROWS)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  apwb_back #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .q_valid   (bq_valid),
    .q_item    (bq_item),
    .q_pop     (bq_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
